### hdl/r2y_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and colour arithmetic for the RGB to I420 converter.
package r2y_pkg;

	localparam int DIM_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int LADDR_W    = 22;
	localparam int CADDR_W    = 23;
	localparam int CIDX_W     = 20;
	localparam int AREA_W     = 2 * DIM_W;
	localparam int SUM_W      = 26;
	localparam int FRAC_W     = 16;

	localparam int DEF_MAX_WIDTH    = 2048;
	localparam int DEF_MAX_HEIGHT   = 2048;
	localparam int RESET_WIDTH      = 640;
	localparam int RESET_HEIGHT     = 480;
	localparam int MIN_DIM          = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} r2y_reg_t;

	// Q16 coefficients
	localparam logic signed [SUM_W-1:0] KY_R = 26'sd19595;
	localparam logic signed [SUM_W-1:0] KY_G = 26'sd38470;
	localparam logic signed [SUM_W-1:0] KY_B = 26'sd7471;
	localparam logic signed [SUM_W-1:0] KU_R = -26'sd11076;
	localparam logic signed [SUM_W-1:0] KU_G = -26'sd21758;
	localparam logic signed [SUM_W-1:0] KU_B = 26'sd32768;
	localparam logic signed [SUM_W-1:0] KV_R = 26'sd32768;
	localparam logic signed [SUM_W-1:0] KV_G = -26'sd27460;
	localparam logic signed [SUM_W-1:0] KV_B = -26'sd5308;
	localparam logic signed [SUM_W-1:0] CHROMA_BIAS = 26'sd8388608;

	typedef struct packed {
		logic [7:0] red_value;
		logic [7:0] green_value;
		logic [7:0] blue_value;
	} r2y_pixel_t;

	typedef struct packed {
		logic [7:0]         luma_value;
		logic [LADDR_W-1:0] luma_address;
		logic               chroma_valid;
		logic [7:0]         u_value;
		logic [7:0]         v_value;
		logic [CADDR_W-1:0] u_address;
		logic [CADDR_W-1:0] v_address;
		logic               end_of_frame;
	} r2y_result_t;

	// Raster position of the pixel being taken in
	typedef struct packed {
		logic [LADDR_W-1:0] pixel_index;
		logic [CIDX_W-1:0]  chroma_index;
		logic               chroma;
		logic               eof;
	} r2y_pos_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int max_dim);
		logic [DIM_W-1:0] r;
		r = v;
		if (int'(v) < MIN_DIM)
			r = DIM_W'(MIN_DIM);
		else if (int'(v) > max_dim)
			r = DIM_W'(max_dim);
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] ext(input logic [7:0] c);
		return $signed(SUM_W'(c));
	endfunction

	function automatic logic signed [SUM_W-1:0] luma_sum(input r2y_pixel_t p);
		return KY_R * ext(p.red_value) + KY_G * ext(p.green_value)
			+ KY_B * ext(p.blue_value);
	endfunction

	function automatic logic signed [SUM_W-1:0] u_sum(input r2y_pixel_t p);
		return KU_R * ext(p.red_value) + KU_G * ext(p.green_value)
			+ KU_B * ext(p.blue_value) + CHROMA_BIAS;
	endfunction

	function automatic logic signed [SUM_W-1:0] v_sum(input r2y_pixel_t p);
		return KV_R * ext(p.red_value) + KV_G * ext(p.green_value)
			+ KV_B * ext(p.blue_value) + CHROMA_BIAS;
	endfunction

	// Floor to integer, then saturate to a byte
	function automatic logic [7:0] to_byte(input logic signed [SUM_W-1:0] s);
		logic [7:0] r;
		r = s[FRAC_W+7:FRAC_W];
		if (s < 0)
			r = 8'd0;
		else if (s[SUM_W-1:FRAC_W+8] != '0)
			r = 8'hFF;
		return r;
	endfunction

endpackage

### hdl/r2y_raster_counter.sv
`timescale 1ns / 1ps
// Raster position counters: column, row, pixel index and chroma sample index.
module r2y_raster_counter #(
	parameter int MAX_WIDTH  = r2y_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = r2y_pkg::DEF_MAX_HEIGHT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [r2y_pkg::DIM_W-1:0]  width,
	input  logic [r2y_pkg::DIM_W-1:0]  height,
	output r2y_pkg::r2y_pos_t          pos
);

	localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CMP_W = r2y_pkg::DIM_W + 1;

	logic [COL_W-1:0]                  col_q;
	logic [ROW_W-1:0]                  row_q;
	logic [r2y_pkg::LADDR_W-1:0]       pix_q;
	logic [r2y_pkg::CIDX_W-1:0]        cidx_q;
	logic                              last_col;
	logic                              last_row;
	logic                              chroma;
	logic                              eof;

	assign last_col = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(width);
	assign last_row = (CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(height);
	assign chroma   = !col_q[0] && !row_q[0];
	assign eof      = last_col && last_row;

	assign pos.pixel_index  = pix_q;
	assign pos.chroma_index = cidx_q;
	assign pos.chroma       = chroma;
	assign pos.eof          = eof;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pix_q  <= '0;
			cidx_q <= '0;
		end else if (advance) begin
			if (eof) begin
				col_q  <= '0;
				row_q  <= '0;
				pix_q  <= '0;
				cidx_q <= '0;
			end else begin
				pix_q <= pix_q + 1'b1;
				if (chroma)
					cidx_q <= cidx_q + 1'b1;
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

### hdl/rgb_to_yuv420_planar_converter_core.sv
`timescale 1ns / 1ps
// A pixel transfer loads the input register, and the result register takes it from there
// when the result side does not stall (input register, then result register).
// Throughput: one pixel per cycle; the input only holds when the result side stalls.
// A dimension write reaches the plane base addresses through the dimension registers, then the base registers.
// Reset clears both valids and the raster counters; frame size returns to 640 by 480
// (clamped to the maximum dimensions).
// Top level of the RGB to planar YUV 4:2:0 converter.
module rgb_to_yuv420_planar_converter_core #(
	parameter int MAX_WIDTH  = r2y_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = r2y_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  r2y_pkg::r2y_pixel_t           pixel,
	output logic                          result_valid,
	input  logic                          result_stall,
	output r2y_pkg::r2y_result_t          result,
	input  logic                          cfg_write_en,
	input  logic [r2y_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [r2y_pkg::DIM_W-1:0]     cfg_data
);

	localparam logic [r2y_pkg::DIM_W-1:0] RST_W =
		r2y_pkg::clamp_dim(r2y_pkg::DIM_W'(r2y_pkg::RESET_WIDTH), MAX_WIDTH);
	localparam logic [r2y_pkg::DIM_W-1:0] RST_H =
		r2y_pkg::clamp_dim(r2y_pkg::DIM_W'(r2y_pkg::RESET_HEIGHT), MAX_HEIGHT);
	localparam logic [r2y_pkg::AREA_W-1:0] RST_AREA =
		r2y_pkg::AREA_W'(RST_W) * r2y_pkg::AREA_W'(RST_H);
	localparam logic [r2y_pkg::CADDR_W-1:0] RST_VBASE =
		r2y_pkg::CADDR_W'(RST_AREA + (RST_AREA >> 2));

	logic [r2y_pkg::DIM_W-1:0]     width_q;
	logic [r2y_pkg::DIM_W-1:0]     height_q;
	logic [r2y_pkg::AREA_W-1:0]    area;
	logic [r2y_pkg::AREA_W-1:0]    area_q;
	logic [r2y_pkg::CADDR_W-1:0]   vbase_q;

	logic                          adv1;
	logic                          adv2;
	logic                          take;
	r2y_pkg::r2y_pos_t             pos;

	logic                          v_s1;
	r2y_pkg::r2y_pixel_t           pix_s1;
	r2y_pkg::r2y_pos_t             pos_s1;

	logic                          result_valid_q;
	r2y_pkg::r2y_result_t          result_q;

	// Configuration: store dimensions already clamped to the supported range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_W;
			height_q <= RST_H;
		end else if (cfg_write_en) begin
			case (cfg_index)
				r2y_pkg::REG_FRAME_WIDTH:  width_q  <= r2y_pkg::clamp_dim(cfg_data, MAX_WIDTH);
				r2y_pkg::REG_FRAME_HEIGHT: height_q <= r2y_pkg::clamp_dim(cfg_data, MAX_HEIGHT);
				default: ;
			endcase
		end
	end

	assign area = r2y_pkg::AREA_W'(width_q) * r2y_pkg::AREA_W'(height_q);

	// Plane bases: U plane after the luma area, V plane a quarter area further on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q  <= RST_AREA;
			vbase_q <= RST_VBASE;
		end else begin
			area_q  <= area;
			vbase_q <= r2y_pkg::CADDR_W'(area + (area >> 2));
		end
	end

	assign adv2        = !result_valid_q || !result_stall;
	assign adv1        = !v_s1 || adv2;
	assign pixel_stall = !adv1;
	assign take        = pixel_valid && adv1;

	r2y_raster_counter #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (take),
		.width   (width_q),
		.height  (height_q),
		.pos     (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= pixel_valid;
			if (adv2)
				result_valid_q <= v_s1;
		end
	end

	// Stage 1: capture the pixel and its raster position
	always_ff @(posedge clk) begin
		if (take) begin
			pix_s1 <= pixel;
			pos_s1 <= pos;
		end
	end

	// Result: colour matrix, floor and saturate, plane addresses; zero chroma when not sampled
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			result_q.luma_value   <= r2y_pkg::to_byte(r2y_pkg::luma_sum(pix_s1));
			result_q.luma_address <= pos_s1.pixel_index;
			result_q.chroma_valid <= pos_s1.chroma;
			result_q.end_of_frame <= pos_s1.eof;
			if (pos_s1.chroma) begin
				result_q.u_value   <= r2y_pkg::to_byte(r2y_pkg::u_sum(pix_s1));
				result_q.v_value   <= r2y_pkg::to_byte(r2y_pkg::v_sum(pix_s1));
				result_q.u_address <= r2y_pkg::CADDR_W'(area_q +
					r2y_pkg::AREA_W'(pos_s1.chroma_index));
				result_q.v_address <= vbase_q + r2y_pkg::CADDR_W'(pos_s1.chroma_index);
			end else begin
				result_q.u_value   <= '0;
				result_q.v_value   <= '0;
				result_q.u_address <= '0;
				result_q.v_address <= '0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### hdl/r2y_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the converter, bound to the top level.
module r2y_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  pixel_valid,
	input logic                  pixel_stall,
	input logic                  result_valid,
	input logic                  result_stall,
	input r2y_pkg::r2y_result_t  result
);

	// A stalled result stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// With an empty output register the input side is never held off
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !pixel_stall)
		else $error("input stalled with output register empty");

	// Chroma fields read zero on pixels that carry no chroma sample
	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.chroma_valid |->
			result.u_value == 8'd0 && result.v_value == 8'd0 &&
			result.u_address == '0 && result.v_address == '0)
		else $error("chroma fields not cleared");

	// A transfer in shows up at the result port after the input register unless the result side stalls in between
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall ##1 !result_stall |=> result_valid)
		else $error("result missing two cycles after transfer");

endmodule

bind rgb_to_yuv420_planar_converter_core r2y_checker u_r2y_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_valid  (pixel_valid),
	.pixel_stall  (pixel_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
